/* hdl/ffrs_pkg.sv */
// shared constants, types and register codes of the flow field region statistics block
`default_nettype none
package ffrs_pkg;

  localparam int NCH        = 4;
  localparam int VEL_W      = 16;
  localparam int MAG_W      = 17;
  localparam int MAX_PIXELS = 65536;
  localparam int CNT_W      = 17;
  localparam int SUM_W      = 34;
  localparam int MSUM_W     = 34;
  localparam int MSQ_W      = 52;
  localparam int ABS_W      = 30;
  localparam int SQ_W       = 33;
  localparam int RT_W       = 64;
  localparam int RTR_W      = 32;
  localparam int DIVD_W     = 52;
  localparam int DIVS_W     = 32;
  localparam int CC_W       = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = 1;
  localparam int OUT_W      = 16;

  localparam logic [CC_W-1:0] CC_RESET = 3'd2;
  localparam logic [CC_W-1:0] CC_MAX   = 3'd4;
  localparam logic [PADDR_W-3:0] REG_CHANNEL_COUNT = 1'b0;

  typedef logic signed [VEL_W-1:0] vel_t;

  typedef struct packed {
    vel_t [NCH-1:0]  vel;
    logic            last;
    logic [CC_W-1:0] nch;
  } pix_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

/* hdl/ffrs_if.sv */
// pixel request channel and result request channel interfaces
`default_nettype none
interface ffrs_pix_if import ffrs_pkg::*; ();
  logic       valid;
  logic       ready;
  vel_t       vel_ch0;
  vel_t       vel_ch1;
  vel_t       vel_ch2;
  vel_t       vel_ch3;
  logic       frame_last;
  modport source (output valid, vel_ch0, vel_ch1, vel_ch2, vel_ch3, frame_last, input ready);
  modport sink (input valid, vel_ch0, vel_ch1, vel_ch2, vel_ch3, frame_last, output ready);
endinterface

interface ffrs_res_if import ffrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OUT_W-1:0]   mean_magnitude;
  logic [OUT_W-1:0]   stdev_magnitude;
  vel_t               mean_vel0;
  vel_t               mean_vel1;
  vel_t               mean_vel2;
  vel_t               mean_vel3;
  logic [CNT_W-1:0]   pixels_counted;
  modport source (output valid, mean_magnitude, stdev_magnitude, mean_vel0, mean_vel1,
                  mean_vel2, mean_vel3, pixels_counted, input ready);
  modport sink (input valid, mean_magnitude, stdev_magnitude, mean_vel0, mean_vel1,
                mean_vel2, mean_vel3, pixels_counted, output ready);
endinterface
`default_nettype wire

/* hdl/ffrs_front.sv */
// front end: accepts pixel requests, masks unused channels and queues them
`default_nettype none
module ffrs_front import ffrs_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  ffrs_pix_if.sink             in_chan,
  input  wire logic [CC_W-1:0] chan_cnt,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output pix_t                 pop_pix
);

  pix_t              fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    cnt_r, cnt_nxt;
  logic [CC_W-1:0]   nch;
  pix_t              pix_in;
  logic              push, pop;

  // 0 acts as one channel, anything above four as four
  always_comb begin
    if (chan_cnt == '0) begin
      nch = 3'd1;
    end else if (chan_cnt > CC_MAX) begin
      nch = CC_MAX;
    end else begin
      nch = chan_cnt;
    end
  end

  always_comb begin
    pix_in.vel[0] = in_chan.vel_ch0;
    pix_in.vel[1] = (nch > 3'd1) ? in_chan.vel_ch1 : '0;
    pix_in.vel[2] = (nch > 3'd2) ? in_chan.vel_ch2 : '0;
    pix_in.vel[3] = (nch > 3'd3) ? in_chan.vel_ch3 : '0;
    pix_in.last   = in_chan.frame_last;
    pix_in.nch    = nch;
  end

  assign in_chan.ready = (cnt_r != (PTR_W+1)'(FIFO_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign pop_valid     = (cnt_r != '0);
  assign pop           = pop_valid && pop_ready;
  assign pop_pix       = fifo_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= pix_in;
    end
  end

endmodule
`default_nettype wire

/* hdl/ffrs_isqrt.sv */
// iterative integer square root, two radicand bits per cycle
`default_nettype none
module ffrs_isqrt import ffrs_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [RT_W-1:0] x,
  output unit_stat_t           stat,
  output logic [RTR_W-1:0]     res
);

  logic [RT_W-1:0] x_r, res_r, bit_r, trial;
  logic            busy_r, done_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      res_r <= '0;
      bit_r <= RT_W'(1) << (RT_W - 2);
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = res_r[RTR_W-1:0];

endmodule
`default_nettype wire

/* hdl/ffrs_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module ffrs_div import ffrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output unit_stat_t             stat,
  output logic [DIVD_W-1:0]      quo
);

  localparam int CNT_DW = $clog2(DIVD_W);

  logic [DIVS_W-1:0] rem_r, div_r;
  logic [DIVD_W-1:0] quo_r;
  logic [CNT_DW-1:0] cnt_r;
  logic [DIVS_W:0]   trial;
  logic              ge;
  logic              busy_r, done_r;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
      cnt_r <= CNT_DW'(DIVD_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? DIVS_W'(trial - {1'b0, div_r}) : trial[DIVS_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule
`default_nettype wire

/* hdl/ffrs_back.sv */
// back end: per pixel magnitude and accumulation, frame end statistics sequencer
`default_nettype none
module ffrs_back import ffrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic pop_valid,
  output logic      pop_ready,
  input  wire pix_t pop_pix,
  ffrs_res_if.source out_chan
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_SQ   = 14'b00000000000010,
    ST_MAG  = 14'b00000000000100,
    ST_ACC  = 14'b00000000001000,
    ST_MEAN = 14'b00000000010000,
    ST_E2   = 14'b00000000100000,
    ST_VAR  = 14'b00000001000000,
    ST_SD   = 14'b00000010000000,
    ST_ABS  = 14'b00000100000000,
    ST_LEN2 = 14'b00001000000000,
    ST_LEN  = 14'b00010000000000,
    ST_QST  = 14'b00100000000000,
    ST_QW   = 14'b01000000000000,
    ST_PUT  = 14'b10000000000000
  } st_t;

  localparam int QP_W = ABS_W + MAG_W;

  st_t                     st_r, st_nxt;
  pix_t                    pix_r;
  logic [1:0]              k_r;
  logic                    launched_r;
  logic [SQ_W-1:0]         sq_r;
  logic [MAG_W-1:0]        mag_r;
  logic signed [SUM_W-1:0] csum_r [NCH];
  logic [MSUM_W-1:0]       msum_r;
  logic [MSQ_W-1:0]        msq_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [MAG_W-1:0]        mean_r, sd_r;
  logic [SQ_W-1:0]         e2_r, var_r;
  logic [ABS_W-1:0]        absv_r [NCH];
  logic [NCH-1:0]          neg_r;
  logic [2*ABS_W+1:0]      len2_r;
  logic [RTR_W-1:0]        len_r;
  logic [QP_W-1:0]         qprod_r;
  vel_t                    qv_r [NCH];

  logic                    ov_r;
  logic [OUT_W-1:0]        omean_r, osd_r;
  vel_t                    ovel_r [NCH];
  logic [CNT_W-1:0]        ocnt_r;

  // unit hookup
  logic                    rt_start, dv_start;
  logic [RT_W-1:0]         rt_x;
  logic [RTR_W-1:0]        rt_res;
  unit_stat_t              rt_stat, dv_stat;
  logic [DIVD_W-1:0]       dv_dnd, dv_quo;
  logic [DIVS_W-1:0]       dv_dsr;
  logic [CNT_W-1:0]        n_div;

  logic signed [2*VEL_W-1:0] vsq;
  logic [2*MAG_W-1:0]        magsq, mm;
  logic [2*ABS_W-1:0]        asq;
  logic [DIVS_W-1:0]         sabs [NCH];
  logic                      any31, any30;
  logic                      ch_used;
  logic [MAG_W-1:0]          qsat;
  logic [MAG_W-1:0]          qneg;
  logic                      last_k, out_load;

  ffrs_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .x     (rt_x),
    .stat  (rt_stat),
    .res   (rt_res)
  );

  ffrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dnd),
    .divisor  (dv_dsr),
    .stat     (dv_stat),
    .quo      (dv_quo)
  );

  assign n_div  = (cnt_r == '0) ? CNT_W'(1) : cnt_r;
  assign last_k = (k_r == 2'd3);
  assign vsq    = pix_r.vel[k_r] * pix_r.vel[k_r];
  assign magsq  = mag_r * mag_r;
  assign mm     = mean_r * mean_r;
  assign asq    = absv_r[k_r] * absv_r[k_r];
  assign ch_used = ({1'b0, k_r} < pix_r.nch);

  // absolute channel sums, unused channels forced to zero
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      if (i < pix_r.nch) begin
        sabs[i] = csum_r[i][SUM_W-1] ? DIVS_W'(-csum_r[i]) : DIVS_W'(csum_r[i]);
      end else begin
        sabs[i] = '0;
      end
    end
    any31 = 1'b0;
    any30 = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      any31 = any31 | sabs[i][31];
      any30 = any30 | sabs[i][30];
    end
  end

  // quotient saturation for the direction terms
  always_comb begin
    if (neg_r[k_r]) begin
      qsat = (dv_quo > DIVD_W'(32768)) ? MAG_W'(32768) : dv_quo[MAG_W-1:0];
    end else begin
      qsat = (dv_quo > DIVD_W'(32767)) ? MAG_W'(32767) : dv_quo[MAG_W-1:0];
    end
    qneg = MAG_W'(0) - qsat;
  end

  always_comb begin
    rt_start = 1'b0;
    rt_x     = '0;
    dv_start = 1'b0;
    dv_dnd   = '0;
    dv_dsr   = '0;
    unique case (st_r)
      ST_MAG: begin
        rt_start = !launched_r;
        rt_x     = RT_W'(sq_r);
      end
      ST_SD: begin
        rt_start = !launched_r;
        rt_x     = RT_W'(var_r);
      end
      ST_LEN: begin
        rt_start = !launched_r;
        rt_x     = RT_W'(len2_r);
      end
      ST_MEAN: begin
        dv_start = !launched_r;
        dv_dnd   = DIVD_W'(msum_r);
        dv_dsr   = DIVS_W'(n_div);
      end
      ST_E2: begin
        dv_start = !launched_r;
        dv_dnd   = msq_r;
        dv_dsr   = DIVS_W'(n_div);
      end
      ST_QW: begin
        dv_start = !launched_r;
        dv_dnd   = DIVD_W'(qprod_r);
        dv_dsr   = len_r;
      end
      default: begin
      end
    endcase
  end

  assign pop_ready = (st_r == ST_IDLE);
  assign out_load  = (st_r == ST_PUT) && (!ov_r || out_chan.ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (pop_valid) st_nxt = ST_SQ;
      ST_SQ:   if (last_k) st_nxt = ST_MAG;
      ST_MAG:  if (rt_stat.done) st_nxt = ST_ACC;
      ST_ACC:  st_nxt = pix_r.last ? ST_MEAN : ST_IDLE;
      ST_MEAN: if (dv_stat.done) st_nxt = ST_E2;
      ST_E2:   if (dv_stat.done) st_nxt = ST_VAR;
      ST_VAR:  st_nxt = ST_SD;
      ST_SD:   if (rt_stat.done) st_nxt = ST_ABS;
      ST_ABS:  st_nxt = ST_LEN2;
      ST_LEN2: if (last_k) st_nxt = ST_LEN;
      ST_LEN:  if (rt_stat.done) st_nxt = ST_QST;
      ST_QST: begin
        if (ch_used && len_r != '0) begin
          st_nxt = ST_QW;
        end else if (last_k) begin
          st_nxt = ST_PUT;
        end
      end
      ST_QW: begin
        if (dv_stat.done) st_nxt = last_k ? ST_PUT : ST_QST;
      end
      ST_PUT:  if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      launched_r <= 1'b0;
      ov_r       <= 1'b0;
      msum_r     <= '0;
      msq_r      <= '0;
      cnt_r      <= '0;
      for (int i = 0; i < NCH; i++) csum_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (rt_start || dv_start) begin
        launched_r <= 1'b1;
      end else if (rt_stat.done || dv_stat.done) begin
        launched_r <= 1'b0;
      end
      if (st_r == ST_ACC && cnt_r < CNT_W'(MAX_PIXELS)) begin
        for (int i = 0; i < NCH; i++) begin
          csum_r[i] <= csum_r[i] + SUM_W'(pix_r.vel[i]);
        end
        msum_r <= msum_r + MSUM_W'(mag_r);
        msq_r  <= msq_r + MSQ_W'(magsq);
        cnt_r  <= cnt_r + 1'b1;
      end
      if (out_load) begin
        ov_r   <= 1'b1;
        msum_r <= '0;
        msq_r  <= '0;
        cnt_r  <= '0;
        for (int i = 0; i < NCH; i++) csum_r[i] <= '0;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        pix_r <= pop_pix;
        k_r   <= '0;
        sq_r  <= '0;
      end
      ST_SQ: begin
        sq_r <= sq_r + SQ_W'($unsigned(vsq));
        k_r  <= k_r + 1'b1;
      end
      ST_MAG:  if (rt_stat.done) mag_r <= rt_res[MAG_W-1:0];
      ST_MEAN: if (dv_stat.done) mean_r <= dv_quo[MAG_W-1:0];
      ST_E2:   if (dv_stat.done) e2_r <= dv_quo[SQ_W-1:0];
      ST_VAR:  var_r <= (e2_r > SQ_W'(mm)) ? SQ_W'(e2_r - SQ_W'(mm)) : '0;
      ST_SD:   if (rt_stat.done) sd_r <= rt_res[MAG_W-1:0];
      ST_ABS: begin
        for (int i = 0; i < NCH; i++) begin
          neg_r[i] <= (i < pix_r.nch) && csum_r[i][SUM_W-1];
          if (any31) begin
            absv_r[i] <= sabs[i][ABS_W+1:2];
          end else if (any30) begin
            absv_r[i] <= sabs[i][ABS_W:1];
          end else begin
            absv_r[i] <= sabs[i][ABS_W-1:0];
          end
        end
        len2_r <= '0;
        k_r    <= '0;
      end
      ST_LEN2: begin
        len2_r <= len2_r + (2*ABS_W+2)'(asq);
        k_r    <= k_r + 1'b1;
      end
      ST_LEN: begin
        if (rt_stat.done) begin
          len_r <= rt_res;
          k_r   <= '0;
        end
      end
      ST_QST: begin
        if (ch_used && len_r != '0) begin
          qprod_r <= absv_r[k_r] * mean_r;
        end else begin
          qv_r[k_r] <= '0;
          k_r       <= k_r + 1'b1;
        end
      end
      ST_QW: begin
        if (dv_stat.done) begin
          qv_r[k_r] <= neg_r[k_r] ? qneg[VEL_W-1:0] : qsat[VEL_W-1:0];
          k_r       <= k_r + 1'b1;
        end
      end
      ST_PUT: begin
        if (out_load) begin
          omean_r <= mean_r[MAG_W-1] ? '1 : mean_r[OUT_W-1:0];
          osd_r   <= sd_r[MAG_W-1] ? '1 : sd_r[OUT_W-1:0];
          for (int i = 0; i < NCH; i++) ovel_r[i] <= qv_r[i];
          ocnt_r  <= cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid           = ov_r;
  assign out_chan.mean_magnitude  = omean_r;
  assign out_chan.stdev_magnitude = osd_r;
  assign out_chan.mean_vel0       = ovel_r[0];
  assign out_chan.mean_vel1       = ovel_r[1];
  assign out_chan.mean_vel2       = ovel_r[2];
  assign out_chan.mean_vel3       = ovel_r[3];
  assign out_chan.pixels_counted  = ocnt_r;

  a_rt_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rt_start |-> !rt_stat.busy)
    else $error("square root started while busy");

  a_dv_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dv_start |-> !dv_stat.busy)
    else $error("divider started while busy");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PIXELS))
    else $error("pixel count beyond cap");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> (st_r == ST_SQ))
    else $error("popped pixel not taken into work");

endmodule
`default_nettype wire

/* hdl/flow_field_region_statistics_top.sv */
// top level of the flow field region statistics block: config register, front and back
// per pixel the back end sums four channel squares in turn, then runs the iterative square root
// at frame end the back end runs two divides, two square roots and up to four more divides
// the back end takes a new pixel only once it is done with the last one and any frame end work
// a two entry queue between front and back lets pixels be accepted while the back end works
// reset: synchronous active low; channel_count to 2, accumulators and queue cleared
`default_nettype none
module flow_field_region_statistics_top import ffrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ffrs_pix_if.sink                in_chan,
  ffrs_res_if.source              out_chan,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  // config register
  logic [CC_W-1:0] chan_cnt_r;
  logic            reg_hit;

  // queue link between front and back
  logic pop_valid;
  logic pop_ready;
  pix_t pop_pix;

  // register index is the word address
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_CHANNEL_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(chan_cnt_r) : '0;

  // write lands on the access phase of a request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= CC_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      chan_cnt_r <= pwdata[CC_W-1:0];
    end
  end

  // front: takes pixel requests, clamps channel count, masks unused channels
  ffrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .chan_cnt  (chan_cnt_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_pix   (pop_pix)
  );

  // back: magnitude, accumulation and frame end statistics into an output register
  ffrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_pix   (pop_pix),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

/* tb/flow_field_region_statistics_top_tb.sv */
// testbench of the flow field region statistics block: directed table, random frames, predictor
`default_nettype none
module flow_field_region_statistics_top_tb import ffrs_pkg::*; ();

  // generous run limit and the waits that the block's latency suggests
  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_WAIT   = 700;   // covers the frame end divides and roots plus queued pixels
  localparam int RAND_PIXELS  = 1950;

  typedef struct packed {
    logic [OUT_W-1:0] mean_mag;
    logic [OUT_W-1:0] stdev_mag;
    vel_t [NCH-1:0]   mean_vel;
    logic [CNT_W-1:0] npix;
  } frame_stats_t;

  // one row of the directed table; reg_val < 0 means no register write before the row
  typedef struct {
    int           reg_val;
    vel_t         vel [NCH];
    bit           last;
    bit           typed;
    frame_stats_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ffrs_pix_if pix ();
  ffrs_res_if res ();

  flow_field_region_statistics_top u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(pix), .out_chan(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state: our own copy of the accumulators and the register
  logic [CC_W-1:0]   cc_shadow;
  longint            acc_vel [NCH];
  longint unsigned   acc_mag;
  longint unsigned   acc_mag_sq;
  longint unsigned   acc_npix;

  frame_stats_t stats_due [$];   // results still to arrive, oldest first
  int  err_count;
  int  frames_seen;
  int  pixels_sent;
  int  reg_writes;
  longint cycle_count;
  int  hold_len;
  bit  hold_req;

  // clock: period 8
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int used_channels();
    if (cc_shadow == 0) return 1;
    if (cc_shadow > CC_MAX) return NCH;
    return int'(cc_shadow);
  endfunction

  // absorb one accepted pixel; on the frame's last pixel produce the frame statistics
  function automatic bit absorb_pixel(input vel_t v [NCH], input bit last,
                                      output frame_stats_t st);
    int nch;
    longint unsigned sq, mag, n, mean, e2, m2, var_m, sd, mx, len2, len, q;
    longint unsigned absv [NCH];
    bit neg [NCH];
    int sh;
    nch = used_channels();
    st = '0;
    if (acc_npix < MAX_PIXELS) begin
      sq = 0;
      for (int i = 0; i < nch; i++) begin
        acc_vel[i] += longint'(v[i]);
        sq += longint'(v[i]) * longint'(v[i]);
      end
      mag = int_sqrt(sq);
      acc_mag += mag;
      acc_mag_sq += mag * mag;
      acc_npix++;
    end
    if (!last) return 1'b0;
    n = (acc_npix != 0) ? acc_npix : 1;
    mean = acc_mag / n;
    e2 = acc_mag_sq / n;
    m2 = mean * mean;
    var_m = (e2 > m2) ? e2 - m2 : 0;
    sd = int_sqrt(var_m);
    mx = 0;
    for (int i = 0; i < NCH; i++) begin
      absv[i] = 0;
      neg[i] = 1'b0;
    end
    for (int i = 0; i < nch; i++) begin
      neg[i] = acc_vel[i] < 0;
      absv[i] = neg[i] ? $unsigned(-acc_vel[i]) : $unsigned(acc_vel[i]);
      if (absv[i] > mx) mx = absv[i];
    end
    // wide totals share one right shift
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    len2 = 0;
    for (int i = 0; i < nch; i++) begin
      absv[i] >>= sh;
      len2 += absv[i] * absv[i];
    end
    len = int_sqrt(len2);
    st.mean_mag = (mean > 65535) ? 16'hFFFF : mean[15:0];
    st.stdev_mag = (sd > 65535) ? 16'hFFFF : sd[15:0];
    for (int i = 0; i < NCH; i++) begin
      if (i < nch && len != 0) begin
        q = absv[i] * mean / len;
        if (neg[i]) begin
          if (q > 32768) q = 32768;
          st.mean_vel[i] = vel_t'(-longint'(q));
        end else begin
          if (q > 32767) q = 32767;
          st.mean_vel[i] = vel_t'(q);
        end
      end
    end
    st.npix = acc_npix[CNT_W-1:0];
    for (int i = 0; i < NCH; i++) acc_vel[i] = 0;
    acc_mag = 0;
    acc_mag_sq = 0;
    acc_npix = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch frame %0d %s: got %0d expected %0d", frames_seen, what, got, want);
    err_count++;
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, stats_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, and a long hold-off when the sender asks for one
  always @(negedge clk) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_len = 2000;
      res.ready <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len--;
      res.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 4) begin
      // occasional longer stall
      hold_len = $urandom_range(0, 99) < 85 ? $urandom_range(1, 4) : $urandom_range(20, 120);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    frame_stats_t w;
    if (rst_n && res.valid && res.ready) begin
      if (stats_due.size() == 0) begin
        report_mismatch("unexpected result, pixels_counted", res.pixels_counted, 0);
      end else begin
        w = stats_due.pop_front();
        if (res.mean_magnitude !== w.mean_mag)
          report_mismatch("mean_magnitude", res.mean_magnitude, w.mean_mag);
        if (res.stdev_magnitude !== w.stdev_mag)
          report_mismatch("stdev_magnitude", res.stdev_magnitude, w.stdev_mag);
        if (res.mean_vel0 !== w.mean_vel[0])
          report_mismatch("mean_vel0", res.mean_vel0, w.mean_vel[0]);
        if (res.mean_vel1 !== w.mean_vel[1])
          report_mismatch("mean_vel1", res.mean_vel1, w.mean_vel[1]);
        if (res.mean_vel2 !== w.mean_vel[2])
          report_mismatch("mean_vel2", res.mean_vel2, w.mean_vel[2]);
        if (res.mean_vel3 !== w.mean_vel[3])
          report_mismatch("mean_vel3", res.mean_vel3, w.mean_vel[3]);
        if (res.pixels_counted !== w.npix)
          report_mismatch("pixels_counted", res.pixels_counted, w.npix);
      end
      frames_seen++;
    end
  end

  // bus write: setup then access, register takes it at the access edge
  task automatic write_channel_count(input int val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_CHANNEL_COUNT);
    pwdata <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cc_shadow = val[CC_W-1:0];
    reg_writes++;
  endtask

  // drop valid and wait until every expected result is in and the back end has settled
  task automatic settle_block();
    @(negedge clk);
    pix.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // offer one pixel request, hold it until taken, then an optional gap
  task automatic send_pixel(input vel_t v [NCH], input bit last, input bit typed,
                            input frame_stats_t want);
    frame_stats_t st;
    int gap;
    @(negedge clk);
    pix.valid <= 1'b1;
    pix.vel_ch0 <= v[0];
    pix.vel_ch1 <= v[1];
    pix.vel_ch2 <= v[2];
    pix.vel_ch3 <= v[3];
    pix.frame_last <= last;
    do @(posedge clk); while (!pix.ready);
    pixels_sent++;
    if (absorb_pixel(v, last, st)) stats_due.push_back(typed ? want : st);
    gap = $urandom_range(0, 99);
    gap = gap < 70 ? 0 : (gap < 95 ? $urandom_range(1, 3) : $urandom_range(10, 80));
    if (gap > 0) begin
      @(negedge clk);
      pix.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic vel_t pick_vel();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return vel_t'($urandom_range(0, 8)) - 16'sd4;
      3, 4: return vel_t'($urandom_range(0, 4095)) - 16'sd2048;
      default: return vel_t'($urandom_range(0, 65535));
    endcase
  endfunction

  stim_row_t dir_tab [$];

  function automatic void add_row(input int rv, input int v0, input int v1, input int v2,
                                  input int v3, input bit last, input bit typed,
                                  input int mm, input int sd, input int e0, input int e1,
                                  input int e2, input int e3, input int cnt);
    stim_row_t r;
    r.reg_val = rv;
    r.vel[0] = vel_t'(v0);
    r.vel[1] = vel_t'(v1);
    r.vel[2] = vel_t'(v2);
    r.vel[3] = vel_t'(v3);
    r.last = last;
    r.typed = typed;
    r.want.mean_mag = OUT_W'(mm);
    r.want.stdev_mag = OUT_W'(sd);
    r.want.mean_vel[0] = vel_t'(e0);
    r.want.mean_vel[1] = vel_t'(e1);
    r.want.mean_vel[2] = vel_t'(e2);
    r.want.mean_vel[3] = vel_t'(e3);
    r.want.npix = CNT_W'(cnt);
    dir_tab.push_back(r);
  endfunction

  initial begin
    vel_t v [NCH];
    frame_stats_t none;
    int flen, sent_rand, vals_done;
    bit long_hold_done, pause_done;
    none = '0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix.valid = 1'b0;
    pix.vel_ch0 = '0;
    pix.vel_ch1 = '0;
    pix.vel_ch2 = '0;
    pix.vel_ch3 = '0;
    pix.frame_last = 1'b0;
    res.ready = 1'b0;
    hold_req = 1'b0;
    hold_len = 0;
    cycle_count = 0;
    err_count = 0;
    frames_seen = 0;
    pixels_sent = 0;
    reg_writes = 0;
    cc_shadow = CC_RESET;
    for (int i = 0; i < NCH; i++) acc_vel[i] = 0;
    acc_mag = 0;
    acc_mag_sq = 0;
    acc_npix = 0;

    // directed table: typed results where they are obvious, the predictor elsewhere
    // unit vector along channel 0 with the reset channel count of two
    add_row(-1, 4096, 0, 0, 0, 1, 1, 4096, 0, 4096, 0, 0, 0, 1);
    // zero total vector gives zero velocity
    add_row(-1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 1);
    // two pixels that cancel: mean stays, direction vanishes
    add_row(-1, 4096, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-1, -4096, 0, 0, 0, 1, 1, 4096, 0, 0, 0, 0, 0, 2);
    // spread of magnitudes 0 and 8192
    add_row(-1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-1, 8192, 0, 0, 0, 1, 1, 4096, 4096, 4096, 0, 0, 0, 2);
    // all four channels at the negative extreme: magnitude 65536 saturates the mean
    add_row(4, -32768, -32768, -32768, -32768, 1, 1, 65535, 0, -32768, -32768, -32768,
            -32768, 1);
    add_row(-1, 32767, 32767, 32767, 32767, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    // one channel at the negative extreme
    add_row(1, -32768, 1234, -5, 77, 1, 1, 32768, 0, -32768, 0, 0, 0, 1);
    // a count of zero acts as one
    add_row(0, 100, 5000, -7, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-1, -300, -32768, 32767, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    // three channels, mixed signs
    add_row(3, 12000, -9000, 300, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-1, -32768, 32767, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-1, 1, 2, 3, 4, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    // counts above four act as four, and a change of count in mid-frame
    add_row(5, 20000, -20000, 15000, -15000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, 32767, -32768, 100, 100, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(7, -1, 1, -1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-1, 32767, 32767, -32768, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(6, 5, 5, 5, 5, 1, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].reg_val >= 0) begin
        // the block is idle or mid-frame with nothing expected; let it settle first
        settle_block();
        write_channel_count(dir_tab[k].reg_val);
      end
      send_pixel(dir_tab[k].vel, dir_tab[k].last, dir_tab[k].typed, dir_tab[k].want);
    end

    // random frames: mostly short, a few long; register changes between frames
    sent_rand = 0;
    vals_done = 0;
    long_hold_done = 0;
    pause_done = 0;
    while (sent_rand < RAND_PIXELS) begin
      if ($urandom_range(0, 99) < 6) begin
        settle_block();
        // walk every register value once, then pick at random
        write_channel_count(vals_done < 8 ? vals_done : $urandom_range(0, 7));
        vals_done++;
      end
      if (!long_hold_done && sent_rand > RAND_PIXELS / 3) begin
        // receiver holds off while pixels keep coming, so the block fills and stalls
        hold_req = 1'b1;
        long_hold_done = 1;
      end
      if (!pause_done && sent_rand > 2 * RAND_PIXELS / 3) begin
        // sender pauses until every result is back
        @(negedge clk);
        pix.valid <= 1'b0;
        while (stats_due.size() != 0) @(posedge clk);
        pause_done = 1;
      end
      flen = $urandom_range(0, 99) < 85 ? $urandom_range(1, 8) : $urandom_range(20, 80);
      for (int p = 0; p < flen; p++) begin
        for (int i = 0; i < NCH; i++) v[i] = pick_vel();
        send_pixel(v, p == flen - 1, 1'b0, none);
        sent_rand++;
      end
    end

    @(negedge clk);
    pix.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d pixels in %0d frames, %0d register writes over all channel counts",
             pixels_sent, frames_seen, reg_writes);
    $display("included saturated means, zero and cancelling vectors, mid-frame count changes");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", err_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
